### rtl/core/lkvc_pkg.sv
// ---------------------------------------------------------------------------
// lkvc_pkg
// shared types and constants for the lru key-value cache
// ---------------------------------------------------------------------------
package lkvc_pkg;

  localparam int ENTRIES   = 16;
  localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int AGE_W     = IDX_W;
  localparam int CNT_W     = $clog2(ENTRIES + 1);
  localparam int KEY_W     = 32;
  localparam int DATA_W    = 32;
  localparam int CAP_W     = 5;
  localparam int CAP_RESET = (16 > ENTRIES) ? ENTRIES : 16;

  localparam logic signed [DATA_W-1:0] MISS_VALUE = -32'sd1;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    REG_CAPACITY = 2'd0
  } reg_addr_t;

  // result of the parallel search over all entries
  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
    logic [IDX_W-1:0] lru_idx;
  } lkvc_lookup_t;

  // update request to the entry store
  typedef struct packed {
    logic              en;
    logic              fill;
    logic              wr;
    logic [IDX_W-1:0]  idx;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] data;
  } lkvc_cmd_t;

endpackage

### rtl/core/lkvc_lookup.sv
// ---------------------------------------------------------------------------
// lkvc_lookup
// parallel key match, free slot search and lru pick over all entries
// ---------------------------------------------------------------------------
module lkvc_lookup
  import lkvc_pkg::*;
(
  input  logic [KEY_W-1:0]  search_key,
  input  logic              entry_valid [ENTRIES],
  input  logic [KEY_W-1:0]  entry_key   [ENTRIES],
  input  logic [DATA_W-1:0] entry_data  [ENTRIES],
  input  logic [AGE_W-1:0]  entry_age   [ENTRIES],
  input  logic [CNT_W-1:0]  occupied_count,
  output lkvc_lookup_t      result,
  output logic [DATA_W-1:0] hit_data
);

  logic [AGE_W-1:0] oldest_rank;

  // ranks of valid entries form a permutation of 0..count-1
  assign oldest_rank = AGE_W'(occupied_count - CNT_W'(1));

  always_comb begin
    result = '0;
    // walk downward so the lowest index wins
    for (int j = ENTRIES - 1; j >= 0; j--) begin
      if (entry_valid[j] && (entry_key[j] == search_key)) begin
        result.hit     = 1'b1;
        result.hit_idx = IDX_W'(j);
      end
      if (!entry_valid[j]) begin
        result.free_found = 1'b1;
        result.free_idx   = IDX_W'(j);
      end
      if (entry_valid[j] && (entry_age[j] == oldest_rank)) begin
        result.lru_idx = IDX_W'(j);
      end
    end
  end

  assign hit_data = entry_data[result.hit_idx];

endmodule

### rtl/core/lkvc_store.sv
// ---------------------------------------------------------------------------
// lkvc_store
// entry registers: valid bits, keys, data, recency ranks and fill count
// ---------------------------------------------------------------------------
module lkvc_store
  import lkvc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  lkvc_cmd_t         cmd,
  output logic              entry_valid [ENTRIES],
  output logic [KEY_W-1:0]  entry_key   [ENTRIES],
  output logic [DATA_W-1:0] entry_data  [ENTRIES],
  output logic [AGE_W-1:0]  entry_age   [ENTRIES],
  output logic [CNT_W-1:0]  occupied_count
);

  logic [AGE_W-1:0] target_age;

  assign target_age = entry_age[cmd.idx];

  // control state: valid bits, ranks, count
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < ENTRIES; j++) begin
        entry_valid[j] <= 1'b0;
        entry_age[j]   <= '0;
      end
      occupied_count <= '0;
    end else if (cmd.en) begin
      for (int j = 0; j < ENTRIES; j++) begin
        if (IDX_W'(j) == cmd.idx) begin
          entry_age[j] <= '0;
          if (cmd.fill) begin
            entry_valid[j] <= 1'b1;
          end
        end else if (entry_valid[j] && (cmd.fill || (entry_age[j] < target_age))) begin
          entry_age[j] <= entry_age[j] + AGE_W'(1);
        end
      end
      if (cmd.fill) begin
        occupied_count <= occupied_count + CNT_W'(1);
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (cmd.en && cmd.wr) begin
      entry_key[cmd.idx]  <= cmd.key;
      entry_data[cmd.idx] <= cmd.data;
    end
  end

endmodule

### rtl/core/lru_key_value_cache.sv
// ---------------------------------------------------------------------------
// lru_key_value_cache
// fully associative key-value cache with least-recently-used replacement
// ---------------------------------------------------------------------------
// path: a get beat is held in the input register, then its result goes to the result register
// throughput: one beat per cycle; the input stalls only while a get in the
//   input register waits on a full, stalled result register, a put moves on
// reset: all entries invalid, ranks and count zero, capacity = 16
// ---------------------------------------------------------------------------
module lru_key_value_cache
  import lkvc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  // input channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     operation,
  input  logic [KEY_W-1:0]         key,
  input  logic signed [DATA_W-1:0] value,
  // result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     hit,
  output logic signed [DATA_W-1:0] read_value,
  // configuration port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [1:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  // input register stage
  logic              s1_valid;
  op_t               s1_op;
  logic [KEY_W-1:0]  s1_key;
  logic [DATA_W-1:0] s1_value;

  // capacity register, saturated to 1..ENTRIES on write
  logic [CNT_W-1:0]  capacity;
  logic [CAP_W-1:0]  cap_wr;
  logic [CNT_W-1:0]  cap_next;

  // store and search
  logic              entry_valid [ENTRIES];
  logic [KEY_W-1:0]  entry_key   [ENTRIES];
  logic [DATA_W-1:0] entry_data  [ENTRIES];
  logic [AGE_W-1:0]  entry_age   [ENTRIES];
  logic [CNT_W-1:0]  occupied_count;
  lkvc_lookup_t      lk;
  logic [DATA_W-1:0] hit_data;
  lkvc_cmd_t         cmd;

  logic              in_accept;
  logic              out_free;
  logic              advance;
  logic              do_fill;

  // -------------------------------------------------------------------------
  // handshakes
  // -------------------------------------------------------------------------
  // the result register is free when empty or being drained this cycle
  assign out_free  = !out_valid || !out_stall;
  // a put leaves no result, so it always moves on; a get needs a free slot
  assign advance   = s1_valid && ((s1_op == OP_PUT) || out_free);
  assign in_stall  = s1_valid && !advance;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_op    <= op_t'(operation);
      s1_key   <= key;
      s1_value <= value;
    end
  end

  // -------------------------------------------------------------------------
  // configuration
  // -------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cap_wr = pwdata[CAP_W-1:0];

  always_comb begin
    if (cap_wr == '0) begin
      cap_next = CNT_W'(1);
    end else if (32'(cap_wr) > 32'(ENTRIES)) begin
      cap_next = CNT_W'(ENTRIES);
    end else begin
      cap_next = CNT_W'(cap_wr);
    end
  end

  // capacity only changes while the store is empty
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CNT_W'(CAP_RESET);
    end else if (psel && penable && pwrite && pready &&
                 (paddr == REG_CAPACITY) && (occupied_count == '0)) begin
      capacity <= cap_next;
    end
  end

  always_comb begin
    case (reg_addr_t'(paddr))
      REG_CAPACITY: prdata = 32'(capacity);
      default:      prdata = '0;
    endcase
  end

  // -------------------------------------------------------------------------
  // search and update
  // -------------------------------------------------------------------------
  lkvc_lookup u_lookup (
    .search_key     (s1_key),
    .entry_valid    (entry_valid),
    .entry_key      (entry_key),
    .entry_data     (entry_data),
    .entry_age      (entry_age),
    .occupied_count (occupied_count),
    .result         (lk),
    .hit_data       (hit_data)
  );

  // a new key fills the lowest free slot while under capacity
  assign do_fill = !lk.hit && (occupied_count < capacity) && lk.free_found;

  always_comb begin
    cmd      = '0;
    cmd.key  = s1_key;
    cmd.data = s1_value;
    if (lk.hit) begin
      // get or put on a stored key: touch it, a put also rewrites the data
      cmd.en  = advance;
      cmd.idx = lk.hit_idx;
      cmd.wr  = (s1_op == OP_PUT);
    end else if (s1_op == OP_PUT) begin
      // put on a new key: fill a free slot or evict the oldest entry
      cmd.en   = advance;
      cmd.wr   = 1'b1;
      cmd.fill = do_fill;
      cmd.idx  = do_fill ? lk.free_idx : lk.lru_idx;
    end
  end

  lkvc_store u_store (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .entry_valid    (entry_valid),
    .entry_key      (entry_key),
    .entry_data     (entry_data),
    .entry_age      (entry_age),
    .occupied_count (occupied_count)
  );

  // -------------------------------------------------------------------------
  // result register
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && (s1_op == OP_GET)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && (s1_op == OP_GET)) begin
      hit        <= lk.hit;
      read_value <= lk.hit ? hit_data : MISS_VALUE;
    end
  end

  // -------------------------------------------------------------------------
  // assertions
  // -------------------------------------------------------------------------
  // never more entries than the capacity allows
  assert property (@(posedge clk) disable iff (rst) occupied_count <= capacity)
    else $error("occupied count above capacity");

  // input stalls only when a get is blocked by a full, stalled result register
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && (s1_op == OP_GET) && out_valid && out_stall))
    else $error("input stalled without a blocked get");

  // a stored entry is only added by a fill
  assert property (@(posedge clk) disable iff (rst)
    (occupied_count != $past(occupied_count)) |-> $past(cmd.en && cmd.fill))
    else $error("count changed without a fill");

  // a miss always returns all ones
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !hit) |-> (read_value == MISS_VALUE))
    else $error("miss result not minus one");

endmodule
